/* sv/udptg_pkg.sv */
// ----------------------------------------------------------------------------
// udptg_pkg: shared types and constants of the UDP test dispatcher/generator
// Word layouts, operation and channel codes, and the generator text patterns.
// ----------------------------------------------------------------------------
`default_nettype none

package udptg_pkg;

  // Operation codes of an input word; codes above OP_TICK mean nothing.
  typedef enum logic [2:0] {
    OP_RX_HDR  = 3'd0,
    OP_RX_BEAT = 3'd1,
    OP_TX_HDR  = 3'd2,
    OP_TX_BEAT = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  // Destination channel of a result word.
  typedef enum logic [2:0] {
    CH_NONE     = 3'd0,
    CH_APP_HDR  = 3'd1,
    CH_APP_BEAT = 3'd2,
    CH_SHL_HDR  = 3'd3,
    CH_SHL_BEAT = 3'd4,
    CH_REFUSED  = 3'd5
  } chan_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_RECV_TEST_PORT = 1'b0,
    REG_XMIT_TEST_PORT = 1'b1
  } reg_e;

  localparam logic [15:0] RECV_TEST_PORT_RST = 16'd8800;
  localparam logic [15:0] XMIT_TEST_PORT_RST = 16'd8801;

  localparam int unsigned BEAT_BYTES = 8;
  localparam logic [7:0]  FULL_KEEP  = 8'hFF;

  // Generator text, lane 0 in the low byte: "Hi from " and the second chunk.
  localparam logic [63:0] PATTERN_A = 64'h206D_6F72_6620_6948;
  localparam logic [63:0] PATTERN_B = 64'h0A21_3036_554B_4D46;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] in_src_addr;
    logic [15:0] in_src_port;
    logic [31:0] in_dst_addr;
    logic [15:0] in_dst_port;
    logic [15:0] in_length;
    logic [63:0] in_data;
    logic [7:0]  in_keep;
    logic        in_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [31:0] out_src_addr;
    logic [15:0] out_src_port;
    logic [31:0] out_dst_addr;
    logic [15:0] out_dst_port;
    logic [15:0] out_length;
    logic [63:0] out_data;
    logic [7:0]  out_keep;
    logic        out_last;
  } out_word_t;

  // Test request handed from the receive side to the generator.
  typedef struct packed {
    logic        valid;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [15:0] length;
  } test_req_t;

endpackage

`default_nettype wire

/* sv/udptg_rx.sv */
// ----------------------------------------------------------------------------
// udptg_rx: receive-side classifier
// Sorts datagrams by destination port into forward, drop and test request.
// ----------------------------------------------------------------------------
`default_nettype none

module udptg_rx
  import udptg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire in_word_t  word_i,
  input  wire logic [15:0] recv_port_i,
  input  wire logic [15:0] xmit_port_i,
  input  wire logic      gen_busy_i,
  output test_req_t      req_o,
  output out_word_t      res_o
);

  typedef enum logic [1:0] {
    RX_IDLE   = 2'd0,
    RX_STREAM = 2'd1,
    RX_DROP   = 2'd2,
    RX_TEST   = 2'd3
  } rx_mode_e;

  rx_mode_e    mode_q, mode_d;
  logic [31:0] local_addr_q, local_addr_d;
  logic [15:0] local_port_q, local_port_d;

  always_comb begin
    mode_d       = mode_q;
    local_addr_d = local_addr_q;
    local_port_d = local_port_q;
    res_o        = '0;
    res_o.channel = CH_NONE;
    req_o        = '0;
    req_o.src_addr = local_addr_q;
    req_o.src_port = local_port_q;
    // Target socket and length arrive byte-swapped in the first test beat.
    req_o.dst_addr = {word_i.in_data[7:0], word_i.in_data[15:8],
                      word_i.in_data[23:16], word_i.in_data[31:24]};
    req_o.dst_port = {word_i.in_data[39:32], word_i.in_data[47:40]};
    req_o.length   = {word_i.in_data[55:48], word_i.in_data[63:56]};

    case (word_i.operation)
      OP_RX_HDR: begin
        if (mode_q != RX_IDLE) begin
          res_o.channel = CH_REFUSED;
        end else if (word_i.in_dst_port == recv_port_i) begin
          if (accept_i) mode_d = RX_DROP;
        end else if (word_i.in_dst_port == xmit_port_i) begin
          if (accept_i) begin
            local_addr_d = word_i.in_dst_addr;
            local_port_d = word_i.in_dst_port;
            mode_d       = RX_TEST;
          end
        end else begin
          res_o.channel      = CH_APP_HDR;
          res_o.out_src_addr = word_i.in_src_addr;
          res_o.out_src_port = word_i.in_src_port;
          res_o.out_dst_addr = word_i.in_dst_addr;
          res_o.out_dst_port = word_i.in_dst_port;
          if (accept_i) mode_d = RX_STREAM;
        end
      end
      OP_RX_BEAT: begin
        case (mode_q)
          RX_STREAM: begin
            res_o.channel  = CH_APP_BEAT;
            res_o.out_data = word_i.in_data;
            res_o.out_keep = word_i.in_keep;
            res_o.out_last = word_i.in_last;
            if (accept_i && word_i.in_last) mode_d = RX_IDLE;
          end
          RX_DROP: begin
            if (accept_i && word_i.in_last) mode_d = RX_IDLE;
          end
          RX_TEST: begin
            if (gen_busy_i) begin
              res_o.channel = CH_REFUSED;
            end else if (accept_i) begin
              req_o.valid = 1'b1;
              mode_d      = word_i.in_last ? RX_IDLE : RX_STREAM;
            end
          end
          default: begin
            res_o.channel = CH_REFUSED;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= RX_IDLE;
      local_addr_q <= '0;
      local_port_q <= '0;
    end else begin
      mode_q       <= mode_d;
      local_addr_q <= local_addr_d;
      local_port_q <= local_port_d;
    end
  end

endmodule

`default_nettype wire

/* sv/udptg_tx.sv */
// ----------------------------------------------------------------------------
// udptg_tx: transmit-side forwarder and test datagram generator
// Passes application headers and beats, and answers test requests on ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module udptg_tx
  import udptg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire in_word_t  word_i,
  input  wire test_req_t req_i,
  output logic           gen_busy_o,
  output out_word_t      res_o
);

  typedef enum logic [1:0] {
    TX_IDLE   = 2'd0,
    TX_STREAM = 2'd1,
    TX_GEN    = 2'd2
  } tx_mode_e;

  tx_mode_e    mode_q, mode_d;
  logic        pending_q, pending_d;
  logic [15:0] remaining_q, remaining_d;
  logic        phase_q, phase_d;
  // Socket pair of the pending request; read only after a request stored it.
  logic [31:0] pair_src_addr_q;
  logic [15:0] pair_src_port_q;
  logic [31:0] pair_dst_addr_q;
  logic [15:0] pair_dst_port_q;

  logic        gen_full;
  logic [7:0]  gen_keep;
  logic [63:0] gen_mask;
  logic [63:0] gen_text;

  assign gen_busy_o = pending_q || (mode_q == TX_GEN);

  // Keep for the closing beat: low remaining bits set (remaining is 0 to 8 here).
  assign gen_full = remaining_q > 16'(BEAT_BYTES);
  assign gen_keep = gen_full ? FULL_KEEP
                             : 8'((16'd1 << remaining_q[3:0]) - 16'd1);
  assign gen_text = phase_q ? PATTERN_B : PATTERN_A;

  always_comb begin
    for (int i = 0; i < BEAT_BYTES; i++) begin
      gen_mask[8*i +: 8] = {8{gen_keep[i]}};
    end
  end

  always_comb begin
    mode_d      = mode_q;
    pending_d   = pending_q;
    remaining_d = remaining_q;
    phase_d     = phase_q;
    res_o       = '0;
    res_o.channel = CH_NONE;

    // Store a new request from the receive side.
    if (req_i.valid) begin
      pending_d   = 1'b1;
      remaining_d = req_i.length;
    end

    case (word_i.operation)
      OP_TX_HDR: begin
        if (mode_q == TX_IDLE) begin
          res_o.channel      = CH_SHL_HDR;
          res_o.out_src_addr = word_i.in_src_addr;
          res_o.out_src_port = word_i.in_src_port;
          res_o.out_dst_addr = word_i.in_dst_addr;
          res_o.out_dst_port = word_i.in_dst_port;
          res_o.out_length   = word_i.in_length;
          if (accept_i) mode_d = TX_STREAM;
        end else begin
          res_o.channel = CH_REFUSED;
        end
      end
      OP_TX_BEAT: begin
        if (mode_q == TX_STREAM) begin
          res_o.channel  = CH_SHL_BEAT;
          res_o.out_data = word_i.in_data;
          res_o.out_keep = word_i.in_keep;
          res_o.out_last = word_i.in_last;
          if (accept_i && word_i.in_last) mode_d = TX_IDLE;
        end else begin
          res_o.channel = CH_REFUSED;
        end
      end
      OP_TICK: begin
        if (mode_q == TX_IDLE && pending_q) begin
          res_o.channel      = CH_SHL_HDR;
          res_o.out_src_addr = pair_src_addr_q;
          res_o.out_src_port = pair_src_port_q;
          res_o.out_dst_addr = pair_dst_addr_q;
          res_o.out_dst_port = pair_dst_port_q;
          res_o.out_length   = remaining_q;
          if (accept_i) begin
            pending_d = 1'b0;
            phase_d   = 1'b0;
            mode_d    = TX_GEN;
          end
        end else if (mode_q == TX_GEN) begin
          res_o.channel  = CH_SHL_BEAT;
          res_o.out_data = gen_text & gen_mask;
          res_o.out_keep = gen_keep;
          res_o.out_last = !gen_full;
          if (accept_i) begin
            phase_d = !phase_q;
            if (gen_full) begin
              remaining_d = remaining_q - 16'(BEAT_BYTES);
            end else begin
              mode_d = TX_IDLE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= TX_IDLE;
      pending_q   <= 1'b0;
      remaining_q <= '0;
      phase_q     <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      pending_q   <= pending_d;
      remaining_q <= remaining_d;
      phase_q     <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      pair_src_addr_q <= req_i.src_addr;
      pair_src_port_q <= req_i.src_port;
      pair_dst_addr_q <= req_i.dst_addr;
      pair_dst_port_q <= req_i.dst_port;
    end
  end

endmodule

`default_nettype wire

/* sv/udp_test_dispatch_and_generator.sv */
// ----------------------------------------------------------------------------
// udp_test_dispatch_and_generator: UDP test dispatcher and datagram generator
// Receive classifier, transmit forwarder/generator and a two-deep result buffer.
// ----------------------------------------------------------------------------
// Every input word (rx header, rx beat, tx header, tx beat or tick) yields
// exactly one result word, possibly channel "none" or "refused". The block
// takes one word per clock while in_stall_o is low: the result is computed
// in the cycle of acceptance and registered in the output register if that
// is free. A skid register behind the output register lets one more word in
// while the output is stalled; in_stall_o rises only once both are full.
// Configuration writes go straight to the two port registers and must only
// happen while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_test_dispatch_and_generator
  import udptg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input words
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_word_i,
  // Result words
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o,
  // Configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] recv_port_q;
  logic [15:0] xmit_port_q;

  logic        accept;
  logic        gen_busy;
  test_req_t   test_req;
  out_word_t   rx_res;
  out_word_t   tx_res;
  out_word_t   res;

  logic        out_valid_q;
  logic        skid_valid_q;
  out_word_t   out_q;
  out_word_t   skid_q;
  logic        out_free;

  // Hold new words off only once the skid slot is taken.
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_port_q <= RECV_TEST_PORT_RST;
      xmit_port_q <= XMIT_TEST_PORT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RECV_TEST_PORT: recv_port_q <= cfg_data_i;
        REG_XMIT_TEST_PORT: xmit_port_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  udptg_rx u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .word_i      (in_word_i),
    .recv_port_i (recv_port_q),
    .xmit_port_i (xmit_port_q),
    .gen_busy_i  (gen_busy),
    .req_o       (test_req),
    .res_o       (rx_res)
  );

  udptg_tx u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .word_i     (in_word_i),
    .req_i      (test_req),
    .gen_busy_o (gen_busy),
    .res_o      (tx_res)
  );

  // Pick the side that owns the operation; unused codes give "none".
  always_comb begin
    res = '0;
    res.channel = CH_NONE;
    case (in_word_i.operation) inside
      OP_RX_HDR, OP_RX_BEAT:           res = rx_res;
      OP_TX_HDR, OP_TX_BEAT, OP_TICK:  res = tx_res;
      default: begin
      end
    endcase
  end

  // Output register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
